@@ rtl/qet_pkg.sv @@
// types, codes and character helpers shared by the tokenizer modules
package qet_pkg;

   localparam int MaxResults = 3;

   typedef enum logic [2:0] {
      KIND_DATA          = 3'd0,
      KIND_TOKEN_END     = 3'd1,
      KIND_DONE_TOKENS   = 3'd2,
      KIND_DONE_EMPTY    = 3'd3,
      KIND_ERR_QUOTE     = 3'd4,
      KIND_ERR_BACKSLASH = 3'd5
   } out_kind_type;

   typedef enum logic [2:0] {
      ESC_NONE      = 3'd0,
      ESC_BACKSLASH = 3'd1,
      ESC_HEX_START = 3'd2,
      ESC_HEX       = 3'd3,
      ESC_CTRL      = 3'd4,
      ESC_OCT1      = 3'd5,
      ESC_OCT2      = 3'd6
   } esc_mode_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_mode_type;

   typedef enum logic {
      IN_BYTE = 1'b0,
      IN_END  = 1'b1
   } in_kind_type;

   localparam logic [7:0] ChBackslash = 8'h5c;
   localparam logic [7:0] ChSingleQ   = 8'h27;
   localparam logic [7:0] ChDoubleQ   = 8'h22;
   localparam logic [7:0] ChX         = 8'h78;
   localparam logic [7:0] ChC         = 8'h63;
   localparam logic [7:0] CtrlMask    = 8'h1f;

   typedef struct packed {
      out_kind_type kind;
      logic [7:0]   data;
   } result_type;

   typedef struct packed {
      logic [1:0]                      cnt;
      result_type [MaxResults-1:0]     ent;
   } job_type;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0d, 8'h0a};
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c inside {[8'h30:8'h37]};
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
         return {1'b1, v[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
         return {1'b1, v[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         v = c - 8'h37;
         return {1'b1, v[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [7:0] named_escape(input logic [7:0] c);
      case (c)
         8'h61: return 8'h07;
         8'h62: return 8'h08;
         8'h45: return 8'h1b;
         8'h66: return 8'h0c;
         8'h6e: return 8'h0a;
         8'h72: return 8'h0d;
         8'h74: return 8'h09;
         8'h76: return 8'h0b;
         default: return c;
      endcase
   endfunction

endpackage

@@ rtl/qet_front.sv @@
// front end: takes input transactions, runs the tokenizer state and builds result jobs
module qet_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // ch
   input  logic             req_tuser,   // kind
   input  logic             q_full,
   output logic             push,
   output qet_pkg::job_type push_job
);
   import qet_pkg::*;

   logic           in_tok_ff, in_tok_in;
   logic           saw_ff, saw_in;
   quote_mode_type quote_ff, quote_in;
   esc_mode_type   esc_ff, esc_in;
   logic [7:0]     acc_ff, acc_in;
   job_type        job;
   logic           accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (job.cnt != 2'd0);
   assign push_job   = job;

   always_comb begin
      logic [4:0] h;
      logic [7:0] v;
      logic [7:0] q;
      logic       do_plain;
      logic [7:0] c;
      c         = req_tdata;
      h         = hex_digit(c);
      v         = {acc_ff[4:0], c[2:0]};
      q         = 8'd0;
      do_plain  = 1'b0;
      in_tok_in = in_tok_ff;
      saw_in    = saw_ff;
      quote_in  = quote_ff;
      esc_in    = esc_ff;
      acc_in    = acc_ff;
      job       = '0;
      if (req_tuser == IN_END) begin
         if (esc_ff == ESC_BACKSLASH) begin
            job.ent[job.cnt] = '{KIND_ERR_BACKSLASH, 8'd0};
            job.cnt = job.cnt + 2'd1;
         end else begin
            if (esc_ff == ESC_HEX_START) begin
               job.ent[job.cnt] = '{KIND_DATA, ChX};
               job.cnt = job.cnt + 2'd1;
            end else if (esc_ff == ESC_CTRL) begin
               job.ent[job.cnt] = '{KIND_DATA, ChC};
               job.cnt = job.cnt + 2'd1;
            end else if (esc_ff inside {ESC_HEX, ESC_OCT1, ESC_OCT2}) begin
               job.ent[job.cnt] = '{KIND_DATA, acc_ff};
               job.cnt = job.cnt + 2'd1;
            end
            if (quote_ff != QUOTE_NONE) begin
               job.ent[job.cnt] = '{KIND_ERR_QUOTE, 8'd0};
               job.cnt = job.cnt + 2'd1;
            end else begin
               if (in_tok_ff) begin
                  job.ent[job.cnt] = '{KIND_TOKEN_END, 8'd0};
                  job.cnt = job.cnt + 2'd1;
               end
               job.ent[job.cnt] = '{saw_ff ? KIND_DONE_TOKENS : KIND_DONE_EMPTY, 8'd0};
               job.cnt = job.cnt + 2'd1;
            end
         end
         in_tok_in = 1'b0;
         saw_in    = 1'b0;
         quote_in  = QUOTE_NONE;
         esc_in    = ESC_NONE;
         acc_in    = 8'd0;
      end else begin
         case (esc_ff)
            ESC_BACKSLASH: begin
               esc_in = ESC_NONE;
               if (c == ChX) begin
                  esc_in = ESC_HEX_START;
               end else if (c == ChC) begin
                  esc_in = ESC_CTRL;
               end else if (is_oct(c)) begin
                  acc_in = {5'd0, c[2:0]};
                  esc_in = ESC_OCT1;
               end else begin
                  job.ent[job.cnt] = '{KIND_DATA, named_escape(c)};
                  job.cnt = job.cnt + 2'd1;
               end
            end
            ESC_HEX_START, ESC_HEX: begin
               if (h[4]) begin
                  acc_in = (esc_ff == ESC_HEX_START) ? {4'd0, h[3:0]} : {acc_ff[3:0], h[3:0]};
                  esc_in = ESC_HEX;
               end else begin
                  job.ent[job.cnt] = '{KIND_DATA, (esc_ff == ESC_HEX_START) ? ChX : acc_ff};
                  job.cnt  = job.cnt + 2'd1;
                  esc_in   = ESC_NONE;
                  do_plain = 1'b1;
               end
            end
            ESC_CTRL: begin
               job.ent[job.cnt] = '{KIND_DATA, c & CtrlMask};
               job.cnt = job.cnt + 2'd1;
               esc_in  = ESC_NONE;
            end
            ESC_OCT1, ESC_OCT2: begin
               if (is_oct(c)) begin
                  if (esc_ff == ESC_OCT1) begin
                     acc_in = v;
                     esc_in = ESC_OCT2;
                  end else begin
                     job.ent[job.cnt] = '{KIND_DATA, v};
                     job.cnt = job.cnt + 2'd1;
                     esc_in  = ESC_NONE;
                  end
               end else begin
                  job.ent[job.cnt] = '{KIND_DATA, acc_ff};
                  job.cnt  = job.cnt + 2'd1;
                  esc_in   = ESC_NONE;
                  do_plain = 1'b1;
               end
            end
            default: begin
               esc_in   = ESC_NONE;
               do_plain = 1'b1;
            end
         endcase
         // unquoted whitespace between tokens is skipped
         if (do_plain && !(!in_tok_ff && quote_ff == QUOTE_NONE && is_space(c))) begin
            in_tok_in = 1'b1;
            if (!in_tok_ff) begin
               saw_in = 1'b1;
            end
            if (c == ChBackslash) begin
               esc_in = ESC_BACKSLASH;
            end else if (quote_ff != QUOTE_NONE) begin
               q = (quote_ff == QUOTE_SINGLE) ? ChSingleQ : ChDoubleQ;
               if (c == q) begin
                  quote_in = QUOTE_NONE;
               end else begin
                  job.ent[job.cnt] = '{KIND_DATA, c};
                  job.cnt = job.cnt + 2'd1;
               end
            end else if (c == ChDoubleQ) begin
               quote_in = QUOTE_DOUBLE;
            end else if (c == ChSingleQ) begin
               quote_in = QUOTE_SINGLE;
            end else if (is_space(c)) begin
               job.ent[job.cnt] = '{KIND_TOKEN_END, 8'd0};
               job.cnt   = job.cnt + 2'd1;
               in_tok_in = 1'b0;
            end else begin
               job.ent[job.cnt] = '{KIND_DATA, c};
               job.cnt = job.cnt + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tok_ff <= 1'b0;
         saw_ff    <= 1'b0;
         quote_ff  <= QUOTE_NONE;
         esc_ff    <= ESC_NONE;
         acc_ff    <= 8'd0;
      end else if (accept) begin
         in_tok_ff <= in_tok_in;
         saw_ff    <= saw_in;
         quote_ff  <= quote_in;
         esc_ff    <= esc_in;
         acc_ff    <= acc_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == IN_END |=> esc_ff == ESC_NONE && quote_ff == QUOTE_NONE
         && !in_tok_ff && !saw_ff)
      else $error("state not cleared after end of string");

   a_token_marks_saw: assert property (@(posedge clock) disable iff (reset)
      in_tok_ff |-> saw_ff)
      else $error("open token without saw flag");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("job pushed into full queue");

endmodule

@@ rtl/qet_queue.sv @@
// short job queue between the front and back ends
module qet_queue #(
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  qet_pkg::job_type push_job,
   input  logic             pop,
   output qet_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);
   import qet_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type             mem_ff [Depth];
   logic [PtrW-1:0]     wr_ff, wr_in;
   logic [PtrW-1:0]     rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == CntW'(Depth));
   assign empty    = (cnt_ff == '0);
   assign head_job = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Depth))
      else $error("queue count overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

   a_push_nonempty_job: assert property (@(posedge clock) disable iff (reset)
      push |-> push_job.cnt != 2'd0)
      else $error("job with no results queued");

endmodule

@@ rtl/qet_back.sv @@
// back end: sends the results of the head job one transaction at a time
module qet_back (
   input  logic             clock,
   input  logic             reset,
   input  qet_pkg::job_type head_job,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic [2:0]       rsp_tuser,   // out_kind
   output logic             rsp_tlast
);
   import qet_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   result_type cur;

   assign cur        = head_job.ent[idx_ff];
   assign last       = (idx_ff == head_job.cnt - 2'd1);
   assign rsp_tvalid = !empty;
   assign rsp_tdata  = cur.data;
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = last;
   assign pop        = rsp_tvalid && rsp_tready && last;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_tvalid && rsp_tready) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff < head_job.cnt)
      else $error("result index beyond job");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      empty |-> idx_ff == 2'd0)
      else $error("result index not cleared while idle");

   a_pop_resets_idx: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0)
      else $error("index not cleared after last result");

endmodule

@@ rtl/quoted_escaped_tokenizer.sv @@
// shell style tokenizer with c escapes: one string byte per transaction in, token bytes out
// a byte's results are registered in the job queue and sent once earlier jobs are out
// throughput: one input per cycle unless the queue is full; up to 3 results sent per input
// the job queue holds QueueDepth inputs' worth of results, so input stalls only when it fills
// reset (synchronous, active high) clears tokenizer state, queue pointers and result index
module quoted_escaped_tokenizer #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // ch
   input  logic       req_tuser,   // kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [2:0] rsp_tuser,   // out_kind
   output logic       rsp_tlast    // last
);
   import qet_pkg::*;

   logic    push, pop, full, empty;
   job_type push_job, head_job;

   qet_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (full),
      .push       (push),
      .push_job   (push_job)
   );

   qet_queue #(.Depth(QueueDepth)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (full),
      .empty    (empty)
   );

   qet_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
